FILE: src/bss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bss_pkg: shared types and constants of the bounded substring search
// Register indexes, field widths, the control group that drives the match
// cells, and the result item type.
// ---------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 4;
  localparam int unsigned PatW    = 64;
  localparam int unsigned PosW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgPatternBytes  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternLength = 2'd1;

  localparam logic [ByteW-1:0] NulByte = 8'h00;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic advance;  // a text byte of an open search is consumed
    logic restart;  // the byte is the first one of a new search
  } cell_ctrl_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } result_t;

endpackage

FILE: src/bss_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bss_cell: one match cell of the chain
// Holds whether the pattern prefix that ends at this cell matched the text
// up to the previous byte, and hands that flag to the next cell.
// ---------------------------------------------------------------------------
module bss_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bss_pkg::cell_ctrl_t       ctrl_i,
  input  logic [bss_pkg::ByteW-1:0] text_byte_i,
  input  logic [bss_pkg::ByteW-1:0] pattern_char_i,
  input  logic                      link_i,
  output logic                      hit_o,
  output logic                      link_o
);

  logic flag_q, flag_d;
  logic prefix_ok;

  // The head cell starts a fresh prefix on every byte; the others extend
  // the prefix of their left neighbor, which a new search discards.
  assign prefix_ok = IS_HEAD ? 1'b1 : (link_i & ~ctrl_i.restart);
  assign hit_o     = prefix_ok & (text_byte_i == pattern_char_i);
  assign flag_d    = ctrl_i.advance ? hit_o : flag_q;
  assign link_o    = flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

endmodule

FILE: src/bss_out_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bss_out_queue: two-entry result queue
// Lets the search take a new item while a result still waits at the output.
// ---------------------------------------------------------------------------
module bss_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bss_pkg::result_t data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output bss_pkg::result_t data_o
);

  bss_pkg::result_t entry_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign pop     = valid_o & ready_i;
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/bounded_substring_search.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_substring_search: streaming search for a short pattern
// Finds the first occurrence of a configured pattern inside a text window
// that ends at a last flag, a NUL byte or the text length limit.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake                payload
//   -------   ---------  -----------------------  --------------------------------
//   in        input      in_valid_i / in_ready_o  text_byte_i, start_req_i, last_i
//   out       output     out_valid_o/out_ready_i  found_o, position_o
//   cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One text item is taken per cycle while in_ready_o is high. The match decision
// is made in the cycle the byte is accepted by the chain of MAX_PATTERN match
// cells, and its result is in the output queue in the next cycle. The two-entry
// output queue keeps the input open while one result waits; in_ready_o is low
// exactly while two results are queued, even in a cycle where out_ready_i takes
// one of them. After reset the block is idle and waits for an item with
// start_req_i set; the configuration port is always ready.
//
// Each cell j remembers whether pattern characters 0..j matched the text
// ending at the previous byte, so a full match is the combinational hit of
// the cell at the effective pattern length. This replaces a stored window of
// the last seven bytes: the pattern never holds NUL within its used length
// and the text never feeds a NUL into a match, so the cleared window of a new
// search can never match a pattern byte.
// ---------------------------------------------------------------------------
module bounded_substring_search #(
  parameter int unsigned     MAX_PATTERN = 8,
  parameter longint unsigned MAX_TEXT    = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Text items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bss_pkg::ByteW-1:0]   text_byte_i,
  input  logic                        start_req_i,
  input  logic                        last_i,
  // Result items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [bss_pkg::PosW-1:0]    position_o,
  // Configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bss_pkg::PatW-1:0]    cfg_data_i
);

  // The counter must hold MAX_TEXT itself; the subtraction for the position
  // is done at least as wide as the position field.
  localparam int unsigned CntW = $clog2(MAX_TEXT + 1);
  localparam int unsigned SubW = (CntW > bss_pkg::PosW) ? CntW : bss_pkg::PosW;
  localparam logic [CntW-1:0] TextLimit = CntW'(MAX_TEXT);
  localparam logic [bss_pkg::LenW-1:0] MaxLen = bss_pkg::LenW'(MAX_PATTERN);

  // Configuration registers.
  logic [bss_pkg::PatW-1:0] pattern_bytes_q;
  logic [bss_pkg::LenW-1:0] pattern_length_q;

  // Search state.
  logic [CntW-1:0] bytes_seen_q, bytes_seen_d;
  logic            finished_q, finished_d;

  logic                     accept;
  logic                     is_open;
  logic [bss_pkg::LenW-1:0] sat_len, eff_len;
  logic [CntW-1:0]          seen_next;
  logic                     match;
  logic [SubW-1:0]          offset;

  bss_pkg::cell_ctrl_t   cell_ctrl;
  bss_pkg::result_t      result;
  logic                  push;
  logic                  queue_space;
  bss_pkg::result_t      queue_data;

  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] link;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q  <= '0;
      pattern_length_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bss_pkg::CfgPatternBytes:  pattern_bytes_q  <= cfg_data_i;
        bss_pkg::CfgPatternLength: pattern_length_q <= cfg_data_i[bss_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length: saturate, then cut at the first NUL character.
  always_comb begin
    sat_len = (pattern_length_q > MaxLen) ? MaxLen : pattern_length_q;
    eff_len = sat_len;
    for (int j = MAX_PATTERN - 1; j >= 0; j--) begin
      if ((bss_pkg::LenW'(j) < sat_len) &&
          (pattern_bytes_q[8*j +: 8] == bss_pkg::NulByte)) begin
        eff_len = bss_pkg::LenW'(j);
      end
    end
  end

  assign in_ready_o = queue_space;
  assign accept     = in_valid_i & in_ready_o;
  assign is_open    = start_req_i | ~finished_q;
  assign seen_next  = (start_req_i ? '0 : bytes_seen_q) + CntW'(1);

  // Cells advance only on a real text byte of an open search; an empty
  // pattern settles the search before the byte is looked at.
  assign cell_ctrl.restart = start_req_i;
  assign cell_ctrl.advance = accept & is_open & (text_byte_i != bss_pkg::NulByte) &
                             ~(start_req_i & (eff_len == '0));

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    bss_cell #(
      .IS_HEAD (g == 0)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl),
      .text_byte_i    (text_byte_i),
      .pattern_char_i (pattern_bytes_q[8*g +: 8]),
      .link_i         ((g == 0) ? 1'b1 : link[(g == 0) ? 0 : g - 1]),
      .hit_o          (hit[g]),
      .link_o         (link[g])
    );
  end

  // Full match: the cell at the end of the effective pattern hits now.
  always_comb begin
    match = 1'b0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (eff_len == bss_pkg::LenW'(j + 1)) begin
        match = hit[j];
      end
    end
  end

  assign offset = SubW'(seen_next) - SubW'(eff_len);

  always_comb begin
    bytes_seen_d    = bytes_seen_q;
    finished_d      = finished_q;
    push            = 1'b0;
    result.found    = 1'b0;
    result.position = '0;
    if (accept && is_open) begin
      if (start_req_i) begin
        bytes_seen_d = '0;
        finished_d   = 1'b0;
      end
      if (start_req_i && (eff_len == '0)) begin
        // Empty pattern matches at the start of the text.
        push         = 1'b1;
        result.found = 1'b1;
        finished_d   = 1'b1;
      end else if (text_byte_i == bss_pkg::NulByte) begin
        // Terminator ends the window without a match.
        push       = 1'b1;
        finished_d = 1'b1;
      end else begin
        bytes_seen_d = seen_next;
        if (match) begin
          push            = 1'b1;
          result.found    = 1'b1;
          result.position = offset[bss_pkg::PosW-1:0];
          finished_d      = 1'b1;
        end else if (last_i || (seen_next >= TextLimit)) begin
          push       = 1'b1;
          finished_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      finished_q   <= 1'b1;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      finished_q   <= finished_d;
    end
  end

  bss_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .space_o (queue_space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (queue_data)
  );

  assign found_o    = queue_data.found;
  assign position_o = queue_data.position;

endmodule

FILE: src/bss_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bss_checker: port-level checks of the bounded substring search
// Watches the top-level ports and flags result and flow-control slips.
// ---------------------------------------------------------------------------
module bss_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [bss_pkg::ByteW-1:0] text_byte_i,
  input logic                      start_req_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      found_o,
  input logic [bss_pkg::PosW-1:0]  position_o
);

  // A stalled result item holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("stalled result item changed");

  // A miss always reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("not-found result with nonzero position");

  // The input only stalls while results are waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A new search that opens on a terminator settles at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && start_req_i && (text_byte_i == bss_pkg::NulByte)
    |=> out_valid_o)
    else $error("terminator on start byte gave no result");

endmodule

bind bounded_substring_search bss_checker u_bss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .text_byte_i (text_byte_i),
  .start_req_i (start_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .found_o     (found_o),
  .position_o  (position_o)
);
